// ===== hw/rtl/ahe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahe_pkg
// Shared constants, types and sequencer states of the adaptive Huffman encoder.
// ----------------------------------------------------------------------------
package ahe_pkg;

    localparam int MAX_NODES   = 511;
    localparam int NODE_AW     = 9;
    localparam int WEIGHT_BITS = 32;
    localparam int SYM_BITS    = 8;
    localparam int NUM_SYMS    = 256;
    localparam int PATH_DEPTH  = 256;
    localparam int CHUNK_BITS  = 8;
    localparam int CNT_BITS    = 4;
    localparam int COUNT_BITS  = 10;

    localparam logic [NODE_AW-1:0]     ROOT_NODE   = '0;
    localparam logic [NODE_AW-1:0]     ROOT_ORDER  = NODE_AW'(MAX_NODES - 1);
    localparam logic [NODE_AW-1:0]     FIRST_ORDER = NODE_AW'(MAX_NODES - 2);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX  = '1;
    localparam logic [CNT_BITS-1:0]    CHUNK_FULL  = CNT_BITS'(CHUNK_BITS);

    typedef enum logic [4:0] {
        S_IDLE,
        S_LEAF,
        S_PATH_P,
        S_PATH_L,
        S_EMIT_RD,
        S_EMIT_ACC,
        S_PUSH,
        S_LIT,
        S_POST,
        S_SPLIT0,
        S_SPLIT1,
        S_U_TOP,
        S_U_W,
        S_U_SCAN,
        S_U_SCAN_N,
        S_U_SCAN_W,
        S_U_LEAD,
        S_SW1,
        S_SW2,
        S_SW3,
        S_U_INC
    } t_state;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] code_bits;
        logic [CNT_BITS-1:0]   bit_count;
        logic                  is_literal;
        logic                  weight_overflow;
        logic                  last;
    } t_result;

endpackage

// ===== hw/rtl/ahe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahe_if
// Valid/ready channels for symbols in and code chunks out.
// ----------------------------------------------------------------------------
interface ahe_sym_if
    import ahe_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYM_BITS-1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface ahe_code_if
    import ahe_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CHUNK_BITS-1:0] code_bits;
    logic [CNT_BITS-1:0]   bit_count;
    logic                  is_literal;
    logic                  weight_overflow;
    logic                  last;

    modport source (output valid, output code_bits, output bit_count, output is_literal,
                    output weight_overflow, output last, input ready);
    modport sink   (input valid, input code_bits, input bit_count, input is_literal,
                    input weight_overflow, input last, output ready);
endinterface

// ===== hw/rtl/ahe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahe_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ahe_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ahe_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahe_out_buf
// Output register holding one code chunk until its transfer.
// ----------------------------------------------------------------------------
module ahe_out_buf
    import ahe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_item,
    output logic    o_space,
    ahe_code_if.source m_out
);

    logic    r_valid;
    t_result r_item;

    assign o_space = !r_valid || m_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign m_out.valid           = r_valid;
    assign m_out.code_bits       = r_item.code_bits;
    assign m_out.bit_count       = r_item.bit_count;
    assign m_out.is_literal      = r_item.is_literal;
    assign m_out.weight_overflow = r_item.weight_overflow;
    assign m_out.last            = r_item.last;

endmodule

// ===== hw/rtl/adaptive_huffman_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder_core
// FGK adaptive Huffman encoder, one byte in, code chunks of up to 8 bits out.
//
//   channel   dir  payload                                          transfer
//   sym_in    in   symbol[7:0]                                      valid & ready
//   code_out  out  code_bits[7:0] bit_count[3:0] is_literal
//                  weight_overflow last                             valid & ready
//
// one symbol at a time; ready only while the sequencer is idle
// the time per symbol grows with the code depth, the chunks sent, a literal and a
// split, and with the tree levels updated, extra nodes in the weight block scan and swaps
// the single read port of each node RAM sets the pace of path walk and update
// chunks wait in the output register; the sequencer stalls while it is full
// synchronous reset; node RAMs need no clearing, root entries come from registers
// ----------------------------------------------------------------------------
module adaptive_huffman_encoder_core
    import ahe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ahe_sym_if.sink    sym_in,
    ahe_code_if.source code_out
);

    localparam int PATH_AW = $clog2(PATH_DEPTH);

    t_state r_state, n_state;

    logic [SYM_BITS-1:0]    r_sym;
    logic                   r_ovf;
    logic                   r_seen_cur;
    logic [NODE_AW-1:0]     r_start;
    logic [NODE_AW-1:0]     r_q;
    logic [NODE_AW-1:0]     r_p;
    logic [NODE_AW-1:0]     r_depth;
    logic [NODE_AW-1:0]     r_idx;
    logic [CHUNK_BITS-1:0]  r_acc;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [WEIGHT_BITS-1:0] r_root_w;
    logic [NUM_SYMS-1:0]    r_seen_vec;
    logic [NODE_AW-1:0]     r_nyt;
    logic [COUNT_BITS-1:0]  r_node_count;
    logic [NODE_AW-1:0]     r_next_order;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [NODE_AW-1:0]     r_top;
    logic [NODE_AW-1:0]     r_oq;
    logic [NODE_AW-1:0]     r_lead;
    logic [NODE_AW-1:0]     r_cand;
    logic [NODE_AW-1:0]     r_pq;
    logic [NODE_AW-1:0]     r_pb;
    logic                   r_aleft;
    logic                   r_bleft;

    // ram ports
    logic                   par_we, left_we, ord_we, o2n_we, wgt_we, leaf_we, bits_we;
    logic [NODE_AW-1:0]     par_wa, par_wd, par_ra, par_rd;
    logic [NODE_AW-1:0]     left_wa, left_wd, left_ra, left_rd;
    logic [NODE_AW-1:0]     ord_wa, ord_wd, ord_ra, ord_rd;
    logic [NODE_AW-1:0]     o2n_wa, o2n_wd, o2n_ra, o2n_rd;
    logic [NODE_AW-1:0]     wgt_wa, wgt_ra;
    logic [WEIGHT_BITS-1:0] wgt_wd, wgt_rd;
    logic [SYM_BITS-1:0]    leaf_wa, leaf_ra;
    logic [NODE_AW-1:0]     leaf_wd, leaf_rd;
    logic [PATH_AW-1:0]     bits_wa, bits_ra;
    logic                   bits_wd, bits_rd;

    logic                   w_accept;
    logic                   w_space;
    logic                   w_load;
    t_result                w_item;
    logic [NODE_AW-1:0]     w_leaf_q;
    logic [NODE_AW-1:0]     w_top_inc;
    logic [NODE_AW-1:0]     w_cand;
    logic [WEIGHT_BITS-1:0] w_cand_w;
    logic                   w_fits;
    logic                   w_do_swap;
    logic [NODE_AW-1:0]     w_node_a;
    logic [NODE_AW-1:0]     w_node_b;
    logic [NODE_AW-1:0]     w_ord_a;

    assign sym_in.ready = (r_state == S_IDLE);
    assign w_accept     = sym_in.valid && sym_in.ready;
    assign w_leaf_q     = r_seen_cur ? leaf_rd : r_nyt;
    assign w_top_inc    = r_top + NODE_AW'(1);
    assign w_cand       = (w_top_inc == ROOT_ORDER) ? ROOT_NODE : o2n_rd;
    assign w_cand_w     = (r_cand == ROOT_NODE) ? r_root_w : wgt_rd;
    assign w_fits       = (r_node_count + COUNT_BITS'(2)) <= COUNT_BITS'(MAX_NODES);
    assign w_do_swap    = (r_lead != r_q) && (r_lead != r_pq) && (r_lead != ROOT_NODE);
    assign w_node_a     = r_node_count[NODE_AW-1:0];
    assign w_node_b     = w_node_a + NODE_AW'(1);
    assign w_ord_a      = r_next_order - NODE_AW'(1);

    ahe_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_AW)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(par_ra), .o_rdata(par_rd));
    ahe_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_AW)) u_left (
        .i_clk(i_clk), .i_we(left_we), .i_waddr(left_wa), .i_wdata(left_wd),
        .i_raddr(left_ra), .o_rdata(left_rd));
    ahe_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_AW)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ord_ra), .o_rdata(ord_rd));
    ahe_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_AW)) u_o2n (
        .i_clk(i_clk), .i_we(o2n_we), .i_waddr(o2n_wa), .i_wdata(o2n_wd),
        .i_raddr(o2n_ra), .o_rdata(o2n_rd));
    ahe_ram #(.DEPTH(MAX_NODES), .WIDTH(WEIGHT_BITS)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_wa), .i_wdata(wgt_wd),
        .i_raddr(wgt_ra), .o_rdata(wgt_rd));
    ahe_ram #(.DEPTH(NUM_SYMS), .WIDTH(NODE_AW)) u_leaf (
        .i_clk(i_clk), .i_we(leaf_we), .i_waddr(leaf_wa), .i_wdata(leaf_wd),
        .i_raddr(leaf_ra), .o_rdata(leaf_rd));
    ahe_ram #(.DEPTH(PATH_DEPTH), .WIDTH(1)) u_bits (
        .i_clk(i_clk), .i_we(bits_we), .i_waddr(bits_wa), .i_wdata(bits_wd),
        .i_raddr(bits_ra), .o_rdata(bits_rd));

    ahe_out_buf u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load), .i_item(w_item),
        .o_space(w_space), .m_out(code_out));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept) n_state = S_LEAF;
            S_LEAF: begin
                if (w_leaf_q == ROOT_NODE) begin
                    n_state = r_seen_cur ? S_POST : S_LIT;
                end else begin
                    n_state = S_PATH_P;
                end
            end
            S_PATH_P:   n_state = S_PATH_L;
            S_PATH_L:   n_state = (r_p == ROOT_NODE) ? S_EMIT_RD : S_PATH_P;
            S_EMIT_RD:  n_state = S_EMIT_ACC;
            S_EMIT_ACC: begin
                n_state = (r_cnt == CHUNK_FULL - CNT_BITS'(1) || r_idx == NODE_AW'(1))
                          ? S_PUSH : S_EMIT_RD;
            end
            S_PUSH: begin
                if (w_space) begin
                    if (r_idx == '0) begin
                        n_state = r_seen_cur ? S_POST : S_LIT;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_LIT:      if (w_space) n_state = S_POST;
            S_POST: begin
                priority if (r_ovf)      n_state = S_IDLE;
                else if (r_seen_cur)     n_state = S_U_TOP;
                else if (w_fits)         n_state = S_SPLIT0;
                else                     n_state = S_IDLE;
            end
            S_SPLIT0:   n_state = S_SPLIT1;
            S_SPLIT1:   n_state = S_U_TOP;
            S_U_TOP:    n_state = (r_q == ROOT_NODE) ? S_IDLE : S_U_W;
            S_U_W:      n_state = S_U_SCAN;
            S_U_SCAN:   n_state = (r_top < ROOT_ORDER) ? S_U_SCAN_N : S_U_LEAD;
            S_U_SCAN_N: n_state = S_U_SCAN_W;
            S_U_SCAN_W: n_state = (w_cand_w == r_w) ? S_U_SCAN : S_U_LEAD;
            S_U_LEAD:   n_state = w_do_swap ? S_SW1 : S_U_INC;
            S_SW1:      n_state = S_SW2;
            S_SW2:      n_state = S_SW3;
            S_SW3:      n_state = S_U_INC;
            S_U_INC:    n_state = S_U_TOP;
            default:    n_state = S_IDLE;
        endcase
    end

    // ram controls and result push
    always_comb begin
        par_we  = 1'b0; par_wa  = r_q;  par_wd  = r_pb; par_ra  = r_q;
        left_we = 1'b0; left_wa = r_pq; left_wd = r_lead; left_ra = r_pq;
        ord_we  = 1'b0; ord_wa  = r_q;  ord_wd  = r_top; ord_ra  = r_q;
        o2n_we  = 1'b0; o2n_wa  = r_top; o2n_wd = r_q; o2n_ra  = w_top_inc;
        wgt_we  = 1'b0; wgt_wa  = r_q;  wgt_wd  = r_w + WEIGHT_BITS'(1); wgt_ra = r_q;
        leaf_we = 1'b0; leaf_wa = r_sym; leaf_wd = w_node_b; leaf_ra = sym_in.symbol;
        bits_we = 1'b0; bits_wa = r_depth[PATH_AW-1:0]; bits_wd = (left_rd != r_q);
        bits_ra = PATH_AW'(r_idx - NODE_AW'(1));
        w_load  = 1'b0;
        w_item  = '{code_bits: r_acc, bit_count: r_cnt, is_literal: 1'b0,
                    weight_overflow: r_ovf, last: (r_idx == '0) && r_seen_cur};
        unique case (r_state)
            S_LEAF:     par_ra = w_leaf_q;
            S_PATH_P:   left_ra = par_rd;
            S_PATH_L: begin
                par_ra  = r_p;
                bits_we = 1'b1;
            end
            S_PUSH:     w_load = w_space;
            S_LIT: begin
                w_load = w_space;
                w_item = '{code_bits: r_sym, bit_count: CHUNK_FULL, is_literal: 1'b1,
                           weight_overflow: r_ovf, last: 1'b1};
            end
            S_SPLIT0: begin
                left_we = 1'b1; left_wa = r_nyt;    left_wd = w_node_a;
                par_we  = 1'b1; par_wa  = w_node_a; par_wd  = r_nyt;
                wgt_we  = 1'b1; wgt_wa  = w_node_a; wgt_wd  = '0;
                ord_we  = 1'b1; ord_wa  = w_node_a; ord_wd  = w_ord_a;
                o2n_we  = 1'b1; o2n_wa  = w_ord_a;  o2n_wd  = w_node_a;
                leaf_we = 1'b1;
            end
            S_SPLIT1: begin
                par_we = 1'b1; par_wa = w_node_b;     par_wd = r_nyt;
                wgt_we = 1'b1; wgt_wa = w_node_b;     wgt_wd = '0;
                ord_we = 1'b1; ord_wa = w_node_b;     ord_wd = r_next_order;
                o2n_we = 1'b1; o2n_wa = r_next_order; o2n_wd = w_node_b;
            end
            S_U_SCAN_N: wgt_ra = w_cand;
            S_U_LEAD: begin
                par_ra  = r_lead;
                left_ra = r_pq;
            end
            S_SW1:      left_ra = par_rd;
            S_SW2: begin
                left_we = r_aleft; left_wa = r_pq;  left_wd = r_lead;
                par_we  = 1'b1;    par_wa  = r_q;   par_wd  = r_pb;
                ord_we  = 1'b1;    ord_wa  = r_q;   ord_wd  = r_top;
                o2n_we  = 1'b1;    o2n_wa  = r_top; o2n_wd  = r_q;
            end
            S_SW3: begin
                left_we = r_bleft; left_wa = r_pb;   left_wd = r_q;
                par_we  = 1'b1;    par_wa  = r_lead; par_wd  = r_pq;
                ord_we  = 1'b1;    ord_wa  = r_lead; ord_wd  = r_oq;
                o2n_we  = 1'b1;    o2n_wa  = r_oq;   o2n_wd  = r_lead;
            end
            S_U_INC:    wgt_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tree control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_w     <= '0;
            r_seen_vec   <= '0;
            r_nyt        <= ROOT_NODE;
            r_node_count <= COUNT_BITS'(1);
            r_next_order <= FIRST_ORDER;
        end else begin
            if (r_state == S_U_TOP && r_q == ROOT_NODE) begin
                r_root_w <= r_root_w + WEIGHT_BITS'(1);
            end
            if (r_state == S_SPLIT1) begin
                r_seen_vec[r_sym] <= 1'b1;
                r_nyt             <= w_node_a;
                r_node_count      <= r_node_count + COUNT_BITS'(2);
                r_next_order      <= r_next_order - NODE_AW'(2);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_sym      <= sym_in.symbol;
                    r_ovf      <= (r_root_w == WEIGHT_MAX);
                    r_seen_cur <= r_seen_vec[sym_in.symbol];
                    r_depth    <= '0;
                    r_acc      <= '0;
                    r_cnt      <= '0;
                end
            end
            S_LEAF: begin
                r_q     <= w_leaf_q;
                r_start <= w_leaf_q;
                r_idx   <= '0;
            end
            S_PATH_P:   r_p <= par_rd;
            S_PATH_L: begin
                r_depth <= r_depth + NODE_AW'(1);
                r_idx   <= r_depth + NODE_AW'(1);
                r_q     <= r_p;
            end
            S_EMIT_ACC: begin
                r_acc <= {r_acc[CHUNK_BITS-2:0], bits_rd};
                r_cnt <= r_cnt + CNT_BITS'(1);
                r_idx <= r_idx - NODE_AW'(1);
            end
            S_PUSH: begin
                if (w_space) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end
            end
            S_POST:     r_q <= r_start;
            S_SPLIT1:   r_q <= w_node_b;
            S_U_W: begin
                r_w    <= wgt_rd;
                r_top  <= ord_rd;
                r_oq   <= ord_rd;
                r_pq   <= par_rd;
                r_lead <= r_q;
            end
            S_U_SCAN_N: r_cand <= w_cand;
            S_U_SCAN_W: begin
                if (w_cand_w == r_w) begin
                    r_top  <= w_top_inc;
                    r_lead <= r_cand;
                end
            end
            S_SW1: begin
                r_pb    <= par_rd;
                r_aleft <= (left_rd == r_q);
            end
            S_SW2:      r_bleft <= (left_rd == r_lead);
            S_SW3:      r_pq <= r_pb;
            S_U_INC:    r_q <= r_pq;
            default: begin
            end
        endcase
    end

    // checks
    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state == S_PUSH || r_state == S_LIT))
        else $error("result pushed outside a push state");

    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= CHUNK_FULL))
        else $error("code chunk longer than its field");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_root_w == WEIGHT_MAX) |=> (r_root_w == WEIGHT_MAX))
        else $error("saturated root weight changed");

    a_count_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_count[0])
        else $error("node count lost its odd parity");

    a_split_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT0) |-> w_fits && !r_seen_cur && !r_ovf)
        else $error("split of the escape leaf without room or for a seen symbol");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the adaptive Huffman encoder against an FGK code tree kept on the
// bench side: every byte accepted updates a predicted tree, and every code
// chunk that comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ahe_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    class code_scoreboard;
        logic [SYM_BITS-1:0]    nsym   [MAX_NODES];
        logic [NODE_AW-1:0]     nleft  [MAX_NODES];
        logic [NODE_AW-1:0]     nright [MAX_NODES];
        logic [NODE_AW-1:0]     nparent[MAX_NODES];
        logic [NODE_AW-1:0]     norder [MAX_NODES];
        logic [WEIGHT_BITS-1:0] nweight[MAX_NODES];
        logic [NODE_AW-1:0]     by_order[MAX_NODES];
        bit                     seen[NUM_SYMS];
        logic [NODE_AW-1:0]     leaf_of[NUM_SYMS];
        int                     count;
        int                     escape;
        int                     next_ord;
        t_result                pending[$];
        int                     errors;
        int                     checked;
        int                     literals;

        function void clear();
            for (int i = 0; i < MAX_NODES; i++) begin
                nsym[i] = '0; nleft[i] = '0; nright[i] = '0; nparent[i] = '0;
                norder[i] = '0; nweight[i] = '0; by_order[i] = '0;
            end
            foreach (seen[i]) begin
                seen[i] = 1'b0;
                leaf_of[i] = '0;
            end
            norder[0] = ROOT_ORDER;
            count = 1;
            escape = 0;
            next_ord = MAX_NODES - 2;
            pending.delete();
        endfunction

        function void swap_nodes(int a, int b);
            int pa, pb;
            bit aleft, bleft;
            logic [NODE_AW-1:0] t;
            pa = nparent[a];
            pb = nparent[b];
            aleft = (nleft[pa] == a);
            bleft = (nleft[pb] == b);
            if (aleft) nleft[pa] = NODE_AW'(b); else nright[pa] = NODE_AW'(b);
            if (bleft) nleft[pb] = NODE_AW'(a); else nright[pb] = NODE_AW'(a);
            nparent[a] = NODE_AW'(pb);
            nparent[b] = NODE_AW'(pa);
            t = norder[a];
            norder[a] = norder[b];
            norder[b] = t;
            by_order[norder[a]] = NODE_AW'(a);
            by_order[norder[b]] = NODE_AW'(b);
        endfunction

        function void climb(int leaf);
            int q, top, leader;
            logic [WEIGHT_BITS-1:0] w;
            q = leaf;
            for (int s = 0; s <= MAX_NODES; s++) begin
                if (q == 0) begin
                    nweight[0] = nweight[0] + WEIGHT_BITS'(1);
                    return;
                end
                w = nweight[q];
                top = norder[q];
                while (top + 1 < MAX_NODES && nweight[by_order[top + 1]] == w) top++;
                leader = by_order[top];
                if (leader != q && leader != nparent[q] && leader != 0)
                    swap_nodes(q, leader);
                nweight[q] = nweight[q] + WEIGHT_BITS'(1);
                q = nparent[q];
            end
        endfunction

        function void push(logic [7:0] code, logic [3:0] cnt, bit lit, bit ovf);
            t_result r;
            r.code_bits = code;
            r.bit_count = cnt;
            r.is_literal = lit;
            r.weight_overflow = ovf;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_symbol(logic [SYM_BITS-1:0] sym);
            bit path[$];
            bit ovf, known;
            int q, p, a, b, n0;
            logic [7:0] acc;
            int cnt;
            ovf = (nweight[0] == WEIGHT_MAX);
            known = seen[sym];
            q = known ? leaf_of[sym] : escape;
            while (q != 0 && path.size() < MAX_NODES) begin
                p = nparent[q];
                path.push_front(nleft[p] == q ? 1'b0 : 1'b1);
                q = p;
            end
            n0 = pending.size();
            acc = '0;
            cnt = 0;
            foreach (path[i]) begin
                acc = {acc[6:0], path[i]};
                cnt++;
                if (cnt == 8) begin
                    push(acc, 4'd8, 1'b0, ovf);
                    acc = '0;
                    cnt = 0;
                end
            end
            if (cnt > 0) push(acc, cnt[3:0], 1'b0, ovf);
            if (!known) begin
                push(sym, CHUNK_FULL, 1'b1, ovf);
                literals++;
            end
            if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
            if (ovf) return;
            if (known) begin
                climb(leaf_of[sym]);
            end else if (count + 2 <= MAX_NODES) begin
                n0 = escape;
                a = count;
                b = count + 1;
                nleft[n0] = NODE_AW'(a);
                nright[n0] = NODE_AW'(b);
                nparent[a] = NODE_AW'(n0);
                nparent[b] = NODE_AW'(n0);
                nleft[a] = '0; nright[a] = '0; nleft[b] = '0; nright[b] = '0;
                nweight[a] = '0;
                nweight[b] = '0;
                nsym[a] = '0;
                nsym[b] = sym;
                norder[b] = NODE_AW'(next_ord);
                norder[a] = NODE_AW'(next_ord - 1);
                by_order[next_ord] = NODE_AW'(b);
                by_order[next_ord - 1] = NODE_AW'(a);
                seen[sym] = 1'b1;
                leaf_of[sym] = NODE_AW'(b);
                escape = a;
                count += 2;
                next_ord -= 2;
                climb(b);
            end
        endfunction

        function void check_chunk(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("unexpected code chunk %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.code_bits !== exp.code_bits) begin
                $error("code_bits exp %h got %h", exp.code_bits, got.code_bits); errors++;
            end
            if (got.bit_count !== exp.bit_count) begin
                $error("bit_count exp %0d got %0d", exp.bit_count, got.bit_count); errors++;
            end
            if (got.is_literal !== exp.is_literal) begin
                $error("is_literal exp %b got %b", exp.is_literal, got.is_literal); errors++;
            end
            if (got.weight_overflow !== exp.weight_overflow) begin
                $error("weight_overflow exp %b got %b", exp.weight_overflow,
                       got.weight_overflow); errors++;
            end
            if (got.last !== exp.last) begin
                $error("last exp %b got %b", exp.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   cycles = 0;
    int   quiet = 0;
    bit   no_idle = 0;
    int   sent = 0;

    ahe_sym_if  sym_in();
    ahe_code_if code_out();

    adaptive_huffman_encoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .sym_in  (sym_in.sink),
        .code_out(code_out.source)
    );

    code_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    initial begin
        sym_in.valid = 0;
        sym_in.symbol = 0;
        code_out.ready = 0;
    end

    // sink side: random stall bursts, checks every transfer
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && code_out.valid && code_out.ready)
                sb.check_chunk({code_out.code_bits, code_out.bit_count, code_out.is_literal,
                                code_out.weight_overflow, code_out.last});
            if (hold > 0) begin
                hold--;
                code_out.ready <= 0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 17) - 1;
                code_out.ready <= 0;
            end else begin
                code_out.ready <= 1;
            end
        end
    end

    // watchdog on stretches without any transfer
    always @(posedge i_clk) begin
        cycles++;
        if ((sym_in.valid && sym_in.ready) || (code_out.valid && code_out.ready)
            || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // valid stays up between back to back symbols; the block is busy then anyway
    task automatic send_symbol(input logic [SYM_BITS-1:0] sym);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            sym_in.valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        sym_in.valid <= 1;
        sym_in.symbol <= sym;
        do @(posedge i_clk); while (!sym_in.ready);
        sb.note_symbol(sym);
        sent++;
    endtask

    task automatic drain();
        sym_in.valid <= 0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    initial begin
        logic [SYM_BITS-1:0] pick;
        sb.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: first symbol, repeats, extremes, alternating bits
        send_symbol(8'h00);
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(8'hFF);
        send_symbol(8'hAA);
        send_symbol(8'h55);
        send_symbol(8'h00);
        for (int i = 0; i < 8; i++) send_symbol(8'(1 << i));
        send_symbol(8'h80);
        send_symbol(8'h7F);
        drain();

        // walk all bytes for a deep tree with long paths and a full store
        for (int i = 0; i < 256; i++) send_symbol(8'((i * 37 + 11) & 8'hFF));
        drain();

        // random: skewed alphabet so weights and swaps stay busy
        for (int i = 0; i < 160; i++) begin
            if (i == 130) no_idle = 1;
            if ($urandom_range(0, 3) == 0)
                pick = SYM_BITS'($urandom_range(0, 255));
            else
                pick = SYM_BITS'($urandom_range(0, 7) << $urandom_range(0, 5));
            send_symbol(pick);
        end
        drain();

        $display("%0d symbols sent, %0d chunks checked, %0d literals in %0d cycles", sent,
                 sb.checked, sb.literals, cycles);
        $display("covered escape splits, full alphabet, deep paths and block swaps");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
